/* src/phe_pkg.sv */
// Package: shared widths, register indexes and defaults of the heterozygosity engine.
`timescale 1ns / 1ps
`default_nettype none
package phe_pkg;

    localparam int IDX_W      = 12;
    localparam int DOSE_W     = 2;
    localparam int NP_W       = 11;
    localparam int NL_W       = 13;
    localparam int SUM_W      = 13;
    localparam int HE_W       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int FRAC_SHIFT = 13;

    localparam int DEF_MAX_LOCI  = 4096;
    localparam int DEF_MAX_PAIRS = 1024;

    localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
    localparam logic [DOSE_W-1:0] DOSE_MAX = 2'd2;
    localparam logic [DOSE_W-1:0] DOSE_BAD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_PAIRS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LOCI  = 1'd1;

    typedef logic [IDX_W-1:0]      t_locus;
    typedef logic [DOSE_W-1:0]     t_dose;
    typedef logic [HE_W-1:0]       t_he;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

endpackage
`default_nettype wire

/* src/phe_sum_mem.sv */
// Per-locus dosage sum store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module phe_sum_mem #(
    parameter int DEPTH = phe_pkg::DEF_MAX_LOCI,
    parameter int AW    = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [phe_pkg::SUM_W-1:0] i_wdata,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [phe_pkg::SUM_W-1:0] o_rdata
);
    import phe_pkg::*;

    logic [SUM_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* src/phe_div.sv */
// Iterative restoring divider: one quotient bit per cycle of num * 2^13 / den.
`timescale 1ns / 1ps
`default_nettype none
module phe_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 35
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [NUM_W-1:0]         i_num,
    input  wire logic [DEN_W-1:0]         i_den,
    output logic                          o_done,
    output logic      [phe_pkg::HE_W-1:0] o_quo
);
    import phe_pkg::*;

    localparam int CW_N  = NUM_W + FRAC_SHIFT;
    localparam int CW_D  = DEN_W + HE_W - 1;
    localparam int CW    = (CW_N > CW_D) ? CW_N : CW_D;
    localparam int CNT_W = $clog2(HE_W);

    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_dsh;
    logic [HE_W-1:0]  r_quo;
    logic             r_dz;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic             w_ge;

    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HE_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= CW'(i_num) << FRAC_SHIFT;
            r_dsh <= CW'(i_den) << (HE_W - 1);
            r_quo <= '0;
            r_dz  <= (i_den == '0);
        end else if (r_run) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[HE_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dz ? '0 : r_quo;

endmodule
`default_nettype wire

/* src/population_heterozygosity_engine_unit.sv */
// Top level: expected heterozygosity engine, sum store control, locus walk and output.
//
//  channel  | direction | transaction marker     | payload
//  ---------+-----------+------------------------+---------------------------------------
//  item     | in        | start & !busy          | locus_index, female/male dosage, end_of_plan
//  result   | out       | o_done (one cycle)     | o_he_fraction
//  config   | in        | i_cfg_we               | i_cfg_idx, i_cfg_wdata
//
//  Items are accepted every cycle while busy is low: one read-modify-write of the sum memory
//  each, forwarded. An end item holds busy through a flush, a walk that reads and zeroes every
//  memory entry, the drain of the product pipe, forming the divisor and starting the divider,
//  and the division; o_done rises in the same cycle in which busy falls.
//  After reset busy is high while the memory is cleared.
//  The receiver cannot stall: o_done marks o_he_fraction for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module population_heterozygosity_engine_unit #(
    parameter int MAX_LOCI  = phe_pkg::DEF_MAX_LOCI,
    parameter int MAX_PAIRS = phe_pkg::DEF_MAX_PAIRS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire phe_pkg::t_locus    i_locus_index,
    input  wire phe_pkg::t_dose     i_female_dosage,
    input  wire phe_pkg::t_dose     i_male_dosage,
    input  wire logic               i_end_of_plan,
    output logic                    o_done,
    output phe_pkg::t_he            o_he_fraction,
    input  wire logic               i_cfg_we,
    input  wire phe_pkg::t_cfg_idx  i_cfg_idx,
    input  wire phe_pkg::t_cfg_data i_cfg_wdata
);
    import phe_pkg::*;

    localparam int AW     = (MAX_LOCI > 1) ? $clog2(MAX_LOCI) : 1;
    localparam int LCW    = $clog2(MAX_LOCI + 1);
    localparam int PW     = $clog2(MAX_PAIRS + 1);
    localparam int FNW    = PW + 2;
    localparam int PROD_W = SUM_W + FNW;
    localparam int NUM_W  = PROD_W + LCW;
    localparam int NN_W   = 2 * PW;
    localparam int DEN_W  = NN_W + LCW;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DEN   = 3'd5;
    localparam logic [2:0] ST_DIVGO = 3'd6;
    localparam logic [2:0] ST_DIV   = 3'd7;

    logic [2:0]        r_state;
    logic [NP_W-1:0]   r_cfg_pairs;
    logic [NL_W-1:0]   r_cfg_loci;
    logic [AW-1:0]     r_ptr;
    logic              w_ptr_last;

    logic              w_accept;
    logic              w_in_range;
    logic [AW-1:0]     w_in_addr;
    logic [DOSE_W-1:0] w_f;
    logic [DOSE_W-1:0] w_m;

    logic              r_a_v;
    logic [AW-1:0]     r_a_addr;
    logic [2:0]        r_a_add;
    logic              r_wb_v;
    logic [AW-1:0]     r_wb_addr;
    logic [SUM_W-1:0]  r_wb_data;
    logic [SUM_W-1:0]  w_base;
    logic [SUM_W:0]    w_sum;
    logic [SUM_W-1:0]  w_sat;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [SUM_W-1:0]  w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [SUM_W-1:0]  w_rdata;

    logic [PW-1:0]     r_n;
    logic [LCW-1:0]    r_l;
    logic [FNW-1:0]    w_four_n;
    logic              r_w1_v;
    logic              r_w1_last;
    logic [PROD_W-1:0] r_prod;
    logic              r_p_last;
    logic [NUM_W-1:0]  r_num;
    logic [NN_W-1:0]   r_nn;
    logic [DEN_W-1:0]  r_den;

    logic              w_div_start;
    logic              w_div_done;
    logic [HE_W-1:0]   w_div_quo;
    logic              r_done;
    logic [HE_W-1:0]   r_he;

    assign busy       = (r_state != ST_ACC);
    assign w_accept   = start && !busy;
    assign w_in_range = (32'(i_locus_index) < 32'(MAX_LOCI));
    assign w_in_addr  = AW'(i_locus_index);
    assign w_f        = (i_female_dosage == DOSE_BAD) ? DOSE_MAX : i_female_dosage;
    assign w_m        = (i_male_dosage == DOSE_BAD) ? DOSE_MAX : i_male_dosage;
    assign w_ptr_last = (r_ptr == AW'(MAX_LOCI - 1));

    // Forward the last write: the read issued in the same edge saw the old entry.
    assign w_base = (r_wb_v && (r_wb_addr == r_a_addr)) ? r_wb_data : w_rdata;
    assign w_sum  = {1'b0, w_base} + (SUM_W + 1)'(r_a_add);
    assign w_sat  = w_sum[SUM_W] ? SUM_MAX : w_sum[SUM_W-1:0];

    assign w_we    = r_a_v || (r_state == ST_WALK) || (r_state == ST_CLR);
    assign w_waddr = r_a_v ? r_a_addr : r_ptr;
    assign w_wdata = r_a_v ? w_sat : '0;
    assign w_raddr = (r_state == ST_WALK) ? r_ptr : w_in_addr;

    assign w_four_n    = {r_n, 2'b00};
    assign w_div_start = (r_state == ST_DIVGO);

    phe_sum_mem #(
        .DEPTH (MAX_LOCI),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    phe_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pairs <= NP_W'(1);
            r_cfg_loci  <= NL_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_PAIRS: r_cfg_pairs <= i_cfg_wdata[NP_W-1:0];
                REG_NUM_LOCI:  r_cfg_loci  <= i_cfg_wdata[NL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_ptr     <= '0;
            r_a_v     <= 1'b0;
            r_wb_v    <= 1'b0;
            r_w1_v    <= 1'b0;
            r_w1_last <= 1'b0;
            r_p_last  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_a_v     <= w_accept && w_in_range;
            r_wb_v    <= r_a_v;
            r_w1_v    <= (r_state == ST_WALK) && (32'(r_ptr) < 32'(r_l));
            r_w1_last <= (r_state == ST_WALK) && w_ptr_last;
            r_p_last  <= r_w1_last;
            r_done    <= w_div_done;
            case (r_state)
                ST_CLR: begin
                    r_ptr <= w_ptr_last ? '0 : r_ptr + 1'b1;
                    if (w_ptr_last) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (w_accept && i_end_of_plan) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    r_ptr   <= '0;
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    r_ptr <= w_ptr_last ? '0 : r_ptr + 1'b1;
                    if (w_ptr_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_p_last) begin
                        r_state <= ST_DEN;
                    end
                end
                ST_DEN:   r_state <= ST_DIVGO;
                ST_DIVGO: r_state <= ST_DIV;
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_ACC;
                    end
                end
                default: r_state <= ST_CLR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_addr  <= w_in_addr;
        r_a_add   <= 3'(w_f) + 3'(w_m);
        r_wb_addr <= r_a_addr;
        r_wb_data <= w_sat;
        if (r_w1_v && (32'(w_rdata) < 32'(w_four_n))) begin
            r_prod <= PROD_W'(w_rdata) * PROD_W'(w_four_n - FNW'(w_rdata));
        end else begin
            r_prod <= '0;
        end
        if (r_state == ST_FLUSH) begin
            r_n   <= (32'(r_cfg_pairs) > 32'(MAX_PAIRS)) ? PW'(MAX_PAIRS) : PW'(r_cfg_pairs);
            r_l   <= (32'(r_cfg_loci) > 32'(MAX_LOCI)) ? LCW'(MAX_LOCI) : LCW'(r_cfg_loci);
            r_num <= '0;
        end else if ((r_state == ST_WALK) || (r_state == ST_DRAIN)) begin
            r_num <= r_num + NUM_W'(r_prod);
        end
        r_nn <= NN_W'(r_n) * NN_W'(r_n);
        if (r_state == ST_DEN) begin
            r_den <= DEN_W'(r_nn) * DEN_W'(r_l);
        end
        if (w_div_done) begin
            r_he <= w_div_quo;
        end
    end

    assign o_done        = r_done;
    assign o_he_fraction = r_he;

endmodule
`default_nettype wire

/* src/phe_checker.sv */
// Port-level checker of the heterozygosity engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module phe_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               i_end_of_plan,
    input wire logic               o_done,
    input wire logic [15:0]        o_he_fraction
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_end_of_plan) |=> busy)
        else $error("end transaction did not raise busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a finishing pass");

    a_he_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_he_fraction <= 16'd32768))
        else $error("heterozygosity above one half");

endmodule

bind population_heterozygosity_engine_unit phe_checker u_phe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_end_of_plan (i_end_of_plan),
    .o_done        (o_done),
    .o_he_fraction (o_he_fraction)
);
`default_nettype wire

/* verif/testbench.sv */
// Testbench: heterozygosity engine checked against a bit-accurate predictor.
`timescale 1ns / 1ps
module testbench;
    import phe_pkg::*;

    localparam int     STORE_DEPTH    = 4096;
    localparam int     PAIRS_CAP      = 1024;
    localparam int     LOCI_CAP       = 4096;
    localparam longint Q_SCALE        = 8192;
    localparam longint HE_CEIL        = 65535;
    localparam int     RANDOM_ITEMS   = 1950;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     DRAIN_CYCLES   = 64;
    localparam int     MAX_REPORTS    = 100;
    localparam longint CYCLE_LIMIT    = 40000000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_locus    locus;
        t_dose     female;
        t_dose     male;
        logic      last;
        logic      fixed;
        t_he       he;
        t_cfg_idx  reg_idx;
        t_cfg_data reg_data;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_locus    i_locus_index;
    t_dose     i_female_dosage;
    t_dose     i_male_dosage;
    logic      i_end_of_plan;
    logic      o_done;
    t_he       o_he_fraction;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_wdata;

    logic [SUM_W-1:0] locus_sum [STORE_DEPTH];
    logic [NP_W-1:0]  pairs_reg;
    logic [NL_W-1:0]  loci_reg;
    t_he              pending_he [$];
    t_row             directed_rows [$];
    int               mismatches;
    int               items_sent;
    longint           cycle_count;

    population_heterozygosity_engine_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_locus_index   (i_locus_index),
        .i_female_dosage (i_female_dosage),
        .i_male_dosage   (i_male_dosage),
        .i_end_of_plan   (i_end_of_plan),
        .o_done          (o_done),
        .o_he_fraction   (o_he_fraction),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    function automatic void tally_dosage(input t_locus locus, input t_dose f, input t_dose m);
        int s;
        s = int'(locus_sum[locus]) + int'(f > DOSE_MAX ? DOSE_MAX : f)
            + int'(m > DOSE_MAX ? DOSE_MAX : m);
        if (s > int'(SUM_MAX)) s = int'(SUM_MAX);
        locus_sum[locus] = s[SUM_W-1:0];
    endfunction

    function automatic t_he close_plan();
        longint unsigned n;
        longint unsigned l_used;
        longint unsigned four_n;
        longint unsigned numer;
        longint unsigned denom;
        longint unsigned s;
        longint unsigned q;
        int k;
        n = (pairs_reg > PAIRS_CAP) ? PAIRS_CAP : pairs_reg;
        l_used = (loci_reg > LOCI_CAP) ? LOCI_CAP : loci_reg;
        four_n = 4 * n;
        numer = 0;
        for (k = 0; k < int'(l_used); k++) begin
            s = locus_sum[k];
            if (s < four_n) numer += s * (four_n - s);
        end
        for (k = 0; k < STORE_DEPTH; k++) locus_sum[k] = '0;
        denom = n * n * l_used;
        q = (denom == 0) ? 0 : (numer * Q_SCALE) / denom;
        if (q > HE_CEIL) q = HE_CEIL;
        return q[HE_W-1:0];
    endfunction

    function automatic t_dose pick_dose();
        return ($urandom_range(0, 11) == 0) ? DOSE_BAD : t_dose'($urandom_range(0, 2));
    endfunction

    function automatic int pick_gap(input logic gappy);
        if (!gappy) return 0;
        if ($urandom_range(0, 99) < 4) return $urandom_range(20, 60);
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    task automatic idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start           = 1'b0;
            i_locus_index   = t_locus'($urandom);
            i_female_dosage = t_dose'($urandom);
            i_male_dosage   = t_dose'($urandom);
            i_end_of_plan   = 1'($urandom);
        end
    endtask

    task automatic send_item(input t_locus locus, input t_dose f, input t_dose m,
                             input logic last, input logic fixed, input t_he he);
        t_he want;
        @(negedge i_clk);
        start           = 1'b1;
        i_locus_index   = locus;
        i_female_dosage = f;
        i_male_dosage   = m;
        i_end_of_plan   = last;
        do @(posedge i_clk); while (busy);
        tally_dosage(locus, f, m);
        if (last) begin
            want = close_plan();
            pending_he = {pending_he, (fixed ? he : want)};
        end
        items_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_he.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        @(negedge i_clk);
        start       = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_NUM_PAIRS) begin
            pairs_reg = data[NP_W-1:0];
        end else begin
            loci_reg = data;
        end
    endtask

    task automatic row_item(input t_locus locus, input t_dose f, input t_dose m,
                            input logic last, input logic fixed, input t_he he);
        directed_rows = {directed_rows,
                         t_row'{ROW_ITEM, locus, f, m, last, fixed, he, REG_NUM_PAIRS, '0}};
    endtask

    task automatic row_cfg(input t_cfg_idx idx, input t_cfg_data data);
        directed_rows = {directed_rows,
                         t_row'{ROW_CFG, '0, '0, '0, 1'b0, 1'b0, '0, idx, data}};
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_he.size() == 0) begin
                report($sformatf("he_fraction %0d with no transaction pending", o_he_fraction));
            end else begin
                if (o_he_fraction !== pending_he[0]) begin
                    report($sformatf("he_fraction %0d, expected %0d",
                                     o_he_fraction, pending_he[0]));
                end
                void'(pending_he.pop_front());
            end
        end
    end

    initial begin
        int    k;
        int    style;
        int    n_pairs;
        int    n_loci;
        int    plan_len;
        logic  gappy;
        t_locus loc;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_locus_index   = '0;
        i_female_dosage = '0;
        i_male_dosage   = '0;
        i_end_of_plan   = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_NUM_PAIRS;
        i_cfg_wdata     = '0;
        mismatches      = 0;
        items_sent      = 0;
        cycle_count     = 0;
        pairs_reg       = 1;
        loci_reg        = 1;
        for (k = 0; k < STORE_DEPTH; k++) locus_sum[k] = '0;

        row_item(12'd0, 2'd0, 2'd0, 1'b1, 1'b1, 16'd0);
        row_item(12'd0, 2'd1, 2'd1, 1'b1, 1'b1, 16'd32768);
        row_item(12'd0, 2'd2, 2'd2, 1'b1, 1'b1, 16'd0);
        row_item(12'd0, DOSE_BAD, 2'd0, 1'b1, 1'b1, 16'd32768);
        row_item(12'd0, 2'd0, DOSE_BAD, 1'b1, 1'b1, 16'd32768);
        row_item(12'd0, DOSE_BAD, DOSE_BAD, 1'b1, 1'b1, 16'd0);
        row_item(12'd4095, 2'd2, 2'd1, 1'b0, 1'b0, '0);
        row_item(12'd0, 2'd1, 2'd0, 1'b1, 1'b0, '0);
        row_cfg(REG_NUM_LOCI, 13'd4096);
        row_item(12'd0, 2'd1, 2'd1, 1'b1, 1'b0, '0);
        row_cfg(REG_NUM_PAIRS, 13'd0);
        row_item(12'd1, 2'd2, 2'd0, 1'b1, 1'b1, 16'd0);
        row_cfg(REG_NUM_PAIRS, 13'd1);
        row_cfg(REG_NUM_LOCI, 13'd0);
        row_item(12'd0, 2'd1, 2'd1, 1'b1, 1'b1, 16'd0);
        row_cfg(REG_NUM_LOCI, 13'd2);
        row_item(12'd0, 2'd2, 2'd0, 1'b0, 1'b0, '0);
        row_item(12'd1, 2'd0, 2'd1, 1'b0, 1'b0, '0);
        row_cfg(REG_NUM_PAIRS, 13'd2);
        row_item(12'd1, 2'd1, 2'd0, 1'b1, 1'b0, '0);
        row_cfg(REG_NUM_PAIRS, 13'h07FF);
        row_cfg(REG_NUM_LOCI, 13'h1FFF);
        row_item(12'd4095, 2'd2, 2'd2, 1'b0, 1'b0, '0);
        row_item(12'd4095, DOSE_BAD, 2'd2, 1'b1, 1'b0, '0);
        row_cfg(REG_NUM_PAIRS, 13'h1801);
        row_item(12'd0, 2'd1, 2'd1, 1'b1, 1'b0, '0);
        row_cfg(REG_NUM_LOCI, 13'd1);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        settle();

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            end else begin
                send_item(directed_rows[r].locus, directed_rows[r].female,
                          directed_rows[r].male, directed_rows[r].last,
                          directed_rows[r].fixed, directed_rows[r].he);
                idle(pick_gap(1'b1));
            end
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            style = $urandom_range(0, 99);
            gappy = ($urandom_range(0, 3) != 0);
            n_pairs = $urandom_range(1, 6);
            n_loci  = $urandom_range(1, 12);
            if (style >= 80 && style < 90) begin
                n_pairs = $urandom_range(0, 2047);
                n_loci  = $urandom_range(0, 8191);
            end
            write_reg(REG_NUM_LOCI, t_cfg_data'(n_loci));
            write_reg(REG_NUM_PAIRS, {2'($urandom_range(0, 3)), 11'(n_pairs)});
            plan_len = (style < 80) ? n_pairs * n_loci : $urandom_range(1, 40);
            for (k = 0; k < plan_len; k++) begin
                if (style < 80 && $urandom_range(0, 19) == 0) begin
                    send_item(t_locus'($urandom), pick_dose(), pick_dose(), 1'b0, 1'b0, '0);
                    idle(pick_gap(gappy));
                end
                if (k == plan_len / 2 && $urandom_range(0, 15) == 0) begin
                    settle();
                    write_reg(t_cfg_idx'($urandom_range(0, 1)),
                              t_cfg_data'($urandom_range(1, 6)));
                end
                if (style < 80) begin
                    loc = t_locus'(k % n_loci);
                end else if (style < 90) begin
                    loc = t_locus'($urandom);
                end else begin
                    loc = t_locus'($urandom_range(0, 2 * n_loci + 3));
                end
                send_item(loc, pick_dose(), pick_dose(), k == plan_len - 1, 1'b0, '0);
                idle(pick_gap(gappy));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_he.size() != 0) begin
            report($sformatf("%0d results never arrived", pending_he.size()));
        end
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* population_heterozygosity_engine_unit.f */
src/phe_pkg.sv
src/phe_sum_mem.sv
src/phe_div.sv
src/population_heterozygosity_engine_unit.sv
src/phe_checker.sv
verif/testbench.sv
